// ===== hw/rtl/fms_pkg.sv =====
`default_nettype none

package fms_pkg;

	localparam int CHAR_W   = 8;
	localparam int QLEN_W   = 5;
	localparam int SCORE_W  = 13;
	localparam int SUBSEQ_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int QUERY_SLOTS = 16;
	localparam int SLOTS_PER_WORD = CFG_DATA_W / CHAR_W;

	localparam int SCORE_SUBSTRING_BASE = 1000;
	localparam int SCORE_FLOOR          = -4096;
	localparam int MATCH_POINTS         = 10;
	localparam int ADJACENT_BONUS       = 5;
	localparam int BOUNDARY_BONUS       = 8;

	localparam logic [CHAR_W-1:0] CHAR_SLASH     = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;
	localparam logic [QLEN_W-1:0] QLEN_RESET     = 5'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUERY_LOW  = 2'd0,
		CFG_QUERY_HIGH = 2'd1,
		CFG_QUERY_LEN  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              end_of_text;
	} text_item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] match_score;
		logic                      matched;
		logic                      was_substring;
	} score_item_t;

	// Fold ASCII upper case to lower case
	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fms_if.sv =====
`default_nettype none

interface fms_text_if import fms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              end_of_text;

	modport source (output valid, output text_char, output end_of_text, input ready);
	modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface fms_score_if import fms_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] match_score;
	logic                      matched;
	logic                      was_substring;

	modport source (output valid, output match_score, output matched, output was_substring,
		input ready);
	modport sink   (input valid, input match_score, input matched, input was_substring,
		output ready);
endinterface

interface fms_cfg_if import fms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fuzzy_match_scorer_core.sv =====
// Channel    Dir  Payload                                    Transfer when
// text_in    in   text_char[7:0], end_of_text                valid & ready
// score_out  out  match_score[12:0] signed, matched, was_sub  valid & ready
// cfg        in   index[1:0], data[63:0]                     valid & ready (ready tied high)
//
// One character per cycle unless a stalled result holds back a final character; a result
// reaches score_out once the end_of_text character transfers, passing through the input
// register and then the scoring step into the output register.
// The scoring state update fed back through its registers is the loop setting this rate.
// Reset clears the match state and loads a one-character query of NUL.
// A stalled result only holds back a final character; other characters keep flowing.

`default_nettype none

module fuzzy_match_scorer_core import fms_pkg::*; #(
	parameter int QUERY_MAX = 16,
	parameter int TEXT_MAX  = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fms_text_if.sink   text_in,
	fms_score_if.source score_out,
	fms_cfg_if.sink    cfg
);

	// Query storage: folded on write, so the compare path sees lower case only
	logic [QUERY_SLOTS-1:0][CHAR_W-1:0] query_q;
	logic [QLEN_W-1:0]                  qlen_q;

	logic        valid_s1;
	text_item_t  item_s1;
	logic        advance;
	score_item_t result;
	logic        out_valid_q;
	score_item_t out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
			qlen_q  <= QLEN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_QUERY_LOW: begin
					for (int i = 0; i < SLOTS_PER_WORD; i++) begin
						query_q[i] <= fold(cfg.data[i*CHAR_W +: CHAR_W]);
					end
				end
				CFG_QUERY_HIGH: begin
					for (int i = 0; i < SLOTS_PER_WORD; i++) begin
						query_q[SLOTS_PER_WORD + i] <= fold(cfg.data[i*CHAR_W +: CHAR_W]);
					end
				end
				CFG_QUERY_LEN: begin
					qlen_q <= cfg.data[QLEN_W-1:0];
				end
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	// Advance a character unless it is final and the result slot is still occupied
	assign advance = valid_s1 && (!item_s1.end_of_text || !out_valid_q || score_out.ready);

	fms_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fms_score_core #(
		.QUERY_MAX (QUERY_MAX),
		.TEXT_MAX  (TEXT_MAX)
	) u_score_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.query        (query_q[QUERY_MAX-1:0]),
		.query_length (qlen_q),
		.result       (result)
	);

	// Output register: load on a final character, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (score_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_text) begin
			out_q <= result;
		end
	end

	assign score_out.valid         = out_valid_q;
	assign score_out.match_score   = out_q.match_score;
	assign score_out.matched       = out_q.matched;
	assign score_out.was_substring = out_q.was_substring;

endmodule

`default_nettype wire

// ===== hw/rtl/fms_in_stage.sv =====
`default_nettype none

module fms_in_stage import fms_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fms_text_if.sink    text_in,
	input  wire logic   advance,
	output logic        valid_s1,
	output text_item_t  item_s1
);

	logic accept;

	assign text_in.ready = !valid_s1 || advance;
	assign accept        = text_in.valid && text_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// fold before the register to keep the compare path short
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.text_char   <= fold(text_in.text_char);
			item_s1.end_of_text <= text_in.end_of_text;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fms_score_core.sv =====
`default_nettype none

module fms_score_core import fms_pkg::*; #(
	parameter int QUERY_MAX = 16,
	parameter int TEXT_MAX  = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire text_item_t                          item,
	input  wire logic [QUERY_MAX-1:0][CHAR_W-1:0]    query,
	input  wire logic [QLEN_W-1:0]                   query_length,
	output score_item_t                              result
);

	localparam int LW = $clog2(QUERY_MAX + 1);
	localparam int PW = $clog2(TEXT_MAX);
	localparam int SW = ((PW > 11) ? PW : 11) + 2;

	logic [QUERY_MAX-1:0] pmv_q, pmv_n, mask, end_sel;
	logic [PW-1:0]        pos_q, pos_n, first_pos_q, first_pos_n;
	logic                 found_q, found_n, hit;
	logic [LW-1:0]        cursor_q, cursor_n, len;
	logic                 prev_match_q, prev_match_n;
	logic                 prev_bnd_q, prev_bnd_n;
	logic [SUBSEQ_W-1:0]  subseq_q, subseq_n, add;
	logic [CHAR_W-1:0]    cursor_char;
	logic                 seq_hit;
	logic signed [SW-1:0] sub_diff;

	assign len = (query_length > QLEN_W'(QUERY_MAX)) ? LW'(QUERY_MAX) : LW'(query_length);

	always_comb begin
		mask        = '0;
		end_sel     = '0;
		cursor_char = '0;
		for (int i = 0; i < QUERY_MAX; i++) begin
			mask[i]    = (query[i] == item.text_char) && (LW'(i) < len);
			end_sel[i] = (LW'(i + 1) == len);
			if (cursor_q == LW'(i)) begin
				cursor_char = query[i];
			end
		end
	end

	// shift-and step for the substring rule
	always_comb begin
		pmv_n       = ((pmv_q << 1) | QUERY_MAX'(1)) & mask;
		hit         = |(pmv_n & end_sel);
		found_n     = found_q || hit;
		first_pos_n = first_pos_q;
		if (!found_q && hit) begin
			first_pos_n = pos_q - PW'(len) + PW'(1);
		end
		pos_n = (pos_q < PW'(TEXT_MAX - 1)) ? pos_q + PW'(1) : pos_q;
	end

	// greedy in-order match for the subsequence rule
	always_comb begin
		seq_hit = (cursor_q < len) && (cursor_char == item.text_char);
		add     = SUBSEQ_W'(MATCH_POINTS)
			+ ((prev_match_q || pos_q == '0) ? SUBSEQ_W'(ADJACENT_BONUS) : '0)
			+ (prev_bnd_q ? SUBSEQ_W'(BOUNDARY_BONUS) : '0);
		subseq_n     = seq_hit ? subseq_q + add : subseq_q;
		cursor_n     = seq_hit ? cursor_q + LW'(1) : cursor_q;
		prev_match_n = seq_hit;
		prev_bnd_n   = (item.text_char == CHAR_SLASH) || (item.text_char == CHAR_BACKSLASH);
	end

	always_comb begin
		sub_diff = $signed(SW'(SCORE_SUBSTRING_BASE)) - $signed(SW'(first_pos_n));
		if (sub_diff < $signed(SW'(SCORE_FLOOR))) begin
			sub_diff = $signed(SW'(SCORE_FLOOR));
		end
		result = '0;
		if (len == '0) begin
			result.match_score   = SCORE_W'(SCORE_SUBSTRING_BASE);
			result.matched       = 1'b1;
			result.was_substring = 1'b1;
		end else if (found_n) begin
			result.match_score   = sub_diff[SCORE_W-1:0];
			result.matched       = 1'b1;
			result.was_substring = 1'b1;
		end else if (cursor_n >= len) begin
			result.match_score = SCORE_W'(subseq_n);
			result.matched     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmv_q        <= '0;
			pos_q        <= '0;
			first_pos_q  <= '0;
			found_q      <= 1'b0;
			cursor_q     <= '0;
			prev_match_q <= 1'b0;
			prev_bnd_q   <= 1'b1;
			subseq_q     <= '0;
		end else if (step) begin
			if (item.end_of_text) begin
				pmv_q        <= '0;
				pos_q        <= '0;
				first_pos_q  <= '0;
				found_q      <= 1'b0;
				cursor_q     <= '0;
				prev_match_q <= 1'b0;
				prev_bnd_q   <= 1'b1;
				subseq_q     <= '0;
			end else begin
				pmv_q        <= pmv_n;
				pos_q        <= pos_n;
				first_pos_q  <= first_pos_n;
				found_q      <= found_n;
				cursor_q     <= cursor_n;
				prev_match_q <= prev_match_n;
				prev_bnd_q   <= prev_bnd_n;
				subseq_q     <= subseq_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fms_checker.sv =====
`default_nettype none

module fms_checker import fms_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic signed [SCORE_W-1:0] match_score,
	input wire logic                      matched,
	input wire logic                      was_substring
);

	// a result waiting for transfer stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_sub_implies_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_substring |-> matched)
		else $error("substring flag without match");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> match_score == '0)
		else $error("unmatched result carries a score");

	a_substring_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_substring |-> match_score <= $signed(SCORE_W'(SCORE_SUBSTRING_BASE)))
		else $error("substring score above base");

	a_subseq_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched && !was_substring |-> match_score >= $signed(SCORE_W'(MATCH_POINTS)))
		else $error("subsequence score below one match");

endmodule

bind fuzzy_match_scorer_core fms_checker u_fms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (score_out.valid),
	.out_ready     (score_out.ready),
	.match_score   (score_out.match_score),
	.matched       (score_out.matched),
	.was_substring (score_out.was_substring)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fms_pkg::*;

	// Geometry of the block under test; keep in step with the core's defaults
	localparam int QMAX            = 16;
	localparam int TMAX            = 4096;
	localparam int SETTLE_CYCLES   = 8;      // margin for the result path to settle
	localparam int DRAIN_LIMIT     = 4000;   // cycles to wait for outstanding scores
	localparam int RANDOM_ITEMS    = 660;
	localparam int LONG_TEXT_CHARS = 1050;   // pushes the first hit past position 1000
	localparam int TIMEOUT_NS      = 400_000;

	// Index that maps to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	localparam string PATH_CHARS = "abcdeABCDE/\\._-0";

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fms_text_if  text_bus ();
	fms_score_if score_bus ();
	fms_cfg_if   cfg_bus ();

	fuzzy_match_scorer_core #(
		.QUERY_MAX(QMAX),
		.TEXT_MAX (TMAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_bus),
		.score_out(score_bus),
		.cfg      (cfg_bus)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Scoring predictor: register copies and per-text match state
	// ------------------------------------------------------------------
	logic [CFG_DATA_W-1:0] query_lo_reg;
	logic [CFG_DATA_W-1:0] query_hi_reg;
	logic [QLEN_W-1:0]     query_len_reg;

	logic [QMAX-1:0]     sa_vector;      // shift-and partial match bits
	logic [11:0]         txt_pos;
	logic [11:0]         first_hit_pos;
	logic                hit_found;
	logic [4:0]          seq_cursor;     // next query char for in-order matching
	logic                last_was_hit;
	logic                last_was_sep;
	logic [SUBSEQ_W-1:0] seq_points;

	score_item_t pending_scores[$];     // scores owed by the block, oldest first
	logic [CHAR_W-1:0] text_buf[$];     // characters of the text being sent

	int send_idle_pct = 34;
	int recv_idle_pct = 64;
	int error_count   = 0;
	int chars_sent    = 0;
	int texts_sent    = 0;
	int cfg_writes    = 0;
	int exact_count   = 0;
	int fuzzy_count   = 0;
	int miss_count    = 0;

	typedef struct {
		bit                    reconfig;
		string                 query;
		logic [CFG_DATA_W-1:0] len_word;
		bit                    stray;     // also write the unmapped index first
		string                 text;
		bit                    pinned;    // expected score typed in below
		int                    score;
		bit                    hit;
		bit                    exact;
	} directed_row_t;

	directed_row_t directed_rows[$];

	function automatic logic [CHAR_W-1:0] lower_case(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
	endfunction

	function automatic logic [CHAR_W-1:0] query_byte(input int i);
		logic [CFG_DATA_W-1:0] word;
		word = (i < SLOTS_PER_WORD) ? query_lo_reg : query_hi_reg;
		return word[(i % SLOTS_PER_WORD) * CHAR_W +: CHAR_W];
	endfunction

	function automatic int active_len();
		return (query_len_reg > QMAX) ? QMAX : int'(query_len_reg);
	endfunction

	function automatic void clear_match_state();
		sa_vector     = '0;
		txt_pos       = '0;
		first_hit_pos = '0;
		hit_found     = 1'b0;
		seq_cursor    = '0;
		last_was_hit  = 1'b0;
		last_was_sep  = 1'b1;    // start of text counts as a boundary
		seq_points    = '0;
	endfunction

	// Advance the predictor by one character; return 1 with the score on end of text
	function automatic bit score_char(input logic [CHAR_W-1:0] raw, input logic last,
			output score_item_t res);
		logic [CHAR_W-1:0] c;
		logic [QMAX-1:0]   hits;
		int                len;
		int                add;
		int                score;
		bit                at_start;
		c        = lower_case(raw);
		len      = active_len();
		at_start = (txt_pos == 0);
		hits     = '0;
		res      = '0;

		// substring: shift-and over the active query characters
		for (int i = 0; i < QMAX; i++) begin
			if (i < len && lower_case(query_byte(i)) == c) begin
				hits[i] = 1'b1;
			end
		end
		sa_vector = {sa_vector[QMAX-2:0], 1'b1} & hits;
		if (len > 0 && !hit_found && sa_vector[len-1]) begin
			hit_found     = 1'b1;
			first_hit_pos = txt_pos - 12'(len - 1);
		end

		// subsequence: greedy, with adjacency and boundary bonuses
		if (int'(seq_cursor) < len && lower_case(query_byte(int'(seq_cursor))) == c) begin
			add = MATCH_POINTS;
			if (last_was_hit || at_start) begin
				add += ADJACENT_BONUS;
			end
			if (last_was_sep) begin
				add += BOUNDARY_BONUS;
			end
			seq_points   = seq_points + SUBSEQ_W'(add);
			seq_cursor   = seq_cursor + 5'd1;
			last_was_hit = 1'b1;
		end else begin
			last_was_hit = 1'b0;
		end
		last_was_sep = (c == CHAR_SLASH || c == CHAR_BACKSLASH);

		if (txt_pos < 12'(TMAX - 1)) begin
			txt_pos = txt_pos + 12'd1;
		end

		if (!last) begin
			return 1'b0;
		end

		score = 0;
		if (len == 0) begin
			score             = SCORE_SUBSTRING_BASE;
			res.matched       = 1'b1;
			res.was_substring = 1'b1;
		end else if (hit_found) begin
			score = SCORE_SUBSTRING_BASE - int'(first_hit_pos);
			if (score < SCORE_FLOOR) begin
				score = SCORE_FLOOR;
			end
			res.matched       = 1'b1;
			res.was_substring = 1'b1;
		end else if (int'(seq_cursor) >= len) begin
			score       = int'(seq_points);
			res.matched = 1'b1;
		end
		res.match_score = SCORE_W'(score);
		clear_match_state();
		return 1'b1;
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Score monitor: sample at the rising edge, check against the oldest owed score
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		score_item_t got;
		score_item_t want;
		if (arst_n && score_bus.valid && score_bus.ready) begin
			got.match_score   = score_bus.match_score;
			got.matched       = score_bus.matched;
			got.was_substring = score_bus.was_substring;
			if (pending_scores.size() == 0) begin
				flag_error($sformatf("unexpected score transfer: score=%0d matched=%0b sub=%0b",
					got.match_score, got.matched, got.was_substring));
			end else begin
				want = pending_scores.pop_front();
				if (got.match_score !== want.match_score || got.matched !== want.matched ||
						got.was_substring !== want.was_substring) begin
					flag_error($sformatf("score mismatch: got %0d/%0b/%0b, want %0d/%0b/%0b",
						got.match_score, got.matched, got.was_substring,
						want.match_score, want.matched, want.was_substring));
				end
				if (want.was_substring) begin
					exact_count++;
				end else if (want.matched) begin
					fuzzy_count++;
				end else begin
					miss_count++;
				end
			end
		end
	end

	// Receiver: stall the score channel at random, redrawn every falling edge
	initial begin
		score_bus.ready <= 1'b0;
		forever begin
			@(negedge clk);
			score_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender side: every task starts and ends at a falling edge
	// ------------------------------------------------------------------
	task automatic push_char(input logic [CHAR_W-1:0] c, input logic last, input bit pinned,
			input score_item_t pinned_res);
		score_item_t res;
		// idle the channel for a random number of cycles
		while ($urandom_range(99) < send_idle_pct) begin
			text_bus.valid <= 1'b0;
			@(negedge clk);
		end
		text_bus.valid       <= 1'b1;
		text_bus.text_char   <= c;
		text_bus.end_of_text <= last;
		do @(posedge clk); while (!text_bus.ready);
		// transfer happened: step the predictor now, in acceptance order
		if (score_char(c, last, res)) begin
			pending_scores.push_back(pinned ? pinned_res : res);
		end
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input bit pinned, input score_item_t pinned_res);
		foreach (text_buf[i]) begin
			push_char(text_buf[i], i == text_buf.size() - 1, pinned, pinned_res);
		end
		texts_sent++;
	endtask

	// Drop valid, wait for every owed score up to DRAIN_LIMIT, then let the pipe settle
	task automatic wait_drained();
		int guard;
		text_bus.valid <= 1'b0;
		guard = 0;
		while (pending_scores.size() != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Keep valid up across back-to-back writes; the caller drops it afterwards
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			CFG_QUERY_LOW: begin
				query_lo_reg = value;
			end
			CFG_QUERY_HIGH: begin
				query_hi_reg = value;
			end
			CFG_QUERY_LEN: begin
				query_len_reg = value[QLEN_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic load_query(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
			input logic [CFG_DATA_W-1:0] len_word, input bit stray);
		wait_drained();
		if (stray) begin
			write_reg(CFG_UNMAPPED, {CFG_DATA_W{1'b1}});
		end
		write_reg(CFG_QUERY_LOW, lo);
		write_reg(CFG_QUERY_HIGH, hi);
		write_reg(CFG_QUERY_LEN, len_word);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic [2*CFG_DATA_W-1:0] pack_query(input string s);
		logic [2*CFG_DATA_W-1:0] q;
		q = '0;
		for (int i = 0; i < s.len() && i < QMAX; i++) begin
			q[i*CHAR_W +: CHAR_W] = s[i];
		end
		return q;
	endfunction

	function automatic logic [CHAR_W-1:0] filler_char();
		if ($urandom_range(3) == 0) begin
			return CHAR_W'($urandom_range(255));
		end
		return PATH_CHARS[$urandom_range(PATH_CHARS.len() - 1)];
	endfunction

	// Randomly swap the case of a letter; the block must fold it back
	function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
		if ($urandom_range(1) == 0) begin
			return c;
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			return c - CASE_OFFSET;
		end
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			return c + CASE_OFFSET;
		end
		return c;
	endfunction

	// Pick a fresh query: mostly short path-like strings, sometimes extremes
	task automatic random_query();
		logic [2*CFG_DATA_W-1:0] chars;
		logic [CFG_DATA_W-1:0]   len_word;
		len_word = {$urandom, $urandom};
		case ($urandom_range(11))
			0: len_word[QLEN_W-1:0] = '0;
			1: len_word[QLEN_W-1:0] = QLEN_W'(1);
			2: len_word[QLEN_W-1:0] = QLEN_W'(QMAX);
			3: len_word[QLEN_W-1:0] = '1;
			4: len_word[QLEN_W-1:0] = QLEN_W'($urandom_range(QMAX + 1, 30));
			5: len_word[QLEN_W-1:0] = QLEN_W'($urandom_range(7, QMAX));
			default: len_word[QLEN_W-1:0] = QLEN_W'($urandom_range(1, 6));
		endcase
		case ($urandom_range(9))
			0: chars = {2*CFG_DATA_W{1'b1}};
			1: chars = '0;
			2: chars = {$urandom, $urandom, $urandom, $urandom};
			default: begin
				for (int i = 0; i < QMAX; i++) begin
					chars[i*CHAR_W +: CHAR_W] = filler_char();
				end
			end
		endcase
		load_query(chars[CFG_DATA_W-1:0], chars[2*CFG_DATA_W-1:CFG_DATA_W], len_word,
			$urandom_range(7) == 0);
	endtask

	// Fill text_buf: mostly texts built around the query, some broken, some noise
	task automatic build_text();
		int style;
		int len;
		int keep;
		style = $urandom_range(99);
		len   = active_len();
		text_buf.delete();
		repeat ($urandom_range(4)) text_buf.push_back(filler_char());
		if (style < 30) begin
			// contiguous copy of the query
			for (int i = 0; i < len; i++) begin
				text_buf.push_back(flip_case(query_byte(i)));
			end
		end else if (style < 60) begin
			// query characters in order, with gaps
			for (int i = 0; i < len; i++) begin
				repeat ($urandom_range(2)) text_buf.push_back(filler_char());
				text_buf.push_back(flip_case(query_byte(i)));
			end
		end else if (style < 80) begin
			// in-order prefix, then the remainder reversed
			keep = (len > 0) ? $urandom_range(len - 1) : 0;
			for (int i = 0; i < keep; i++) begin
				text_buf.push_back(query_byte(i));
			end
			for (int i = len - 1; i >= keep; i--) begin
				if ($urandom_range(1) == 0) begin
					text_buf.push_back(filler_char());
				end
				text_buf.push_back(query_byte(i));
			end
		end else begin
			repeat ($urandom_range(1, 12)) text_buf.push_back(CHAR_W'($urandom_range(255)));
		end
		repeat ($urandom_range(3)) text_buf.push_back(filler_char());
		if (text_buf.size() == 0) begin
			text_buf.push_back(filler_char());
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
		int first_char;
		int texts_left;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		first_char    = chars_sent;
		texts_left    = 0;
		while (chars_sent - first_char < budget) begin
			if (texts_left == 0) begin
				random_query();
				texts_left = $urandom_range(4, 12);
			end else if ($urandom_range(19) == 0) begin
				// hold the sender until the block has nothing left to report
				wait_drained();
			end
			build_text();
			send_text(1'b0, '0);
			texts_left--;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [2*CFG_DATA_W-1:0] packed_query;
		score_item_t             typed;
		directed_row_t           row;

		text_bus.valid       <= 1'b0;
		text_bus.text_char   <= '0;
		text_bus.end_of_text <= 1'b0;
		cfg_bus.valid        <= 1'b0;
		cfg_bus.index        <= CFG_QUERY_LOW;
		cfg_bus.data         <= '0;

		query_lo_reg  = '0;
		query_hi_reg  = '0;
		query_len_reg = QLEN_RESET;
		clear_match_state();

		// Directed cases. Typed scores only where they are obvious.
		// after reset: query is one NUL char, so a plain letter cannot match
		directed_rows.push_back('{0, "", 64'd0, 0, "a", 1, 0, 0, 0});
		directed_rows.push_back('{1, "abc", 64'd3, 0, "abc", 1, 1000, 1, 1});
		// case folding, substring found later in the text
		directed_rows.push_back('{0, "", 64'd0, 0, "xABC", 1, 999, 1, 1});
		// subsequence with first-char and slash bonuses
		directed_rows.push_back('{0, "", 64'd0, 0, "a/bc", 0, 0, 0, 0});
		// out of order: never completes
		directed_rows.push_back('{0, "", 64'd0, 0, "acb", 1, 0, 0, 0});
		directed_rows.push_back('{1, "abd", 64'd3, 0, "abxd", 0, 0, 0, 0});
		// query completes early; the trailing 'a' adds nothing
		directed_rows.push_back('{1, "ac", 64'd2, 0, "axcxa", 0, 0, 0, 0});
		// empty query always scores as a substring at position zero
		directed_rows.push_back('{1, "", 64'd0, 0, "z", 1, 1000, 1, 1});
		// length above the maximum acts as sixteen, so the NUL tail must also match
		directed_rows.push_back('{1, "ab", 64'hFFFF_FFFF_FFFF_FFF4, 0, "ab", 1, 0, 0, 0});
		// write to an unmapped index must not disturb the query
		directed_rows.push_back('{1, "q", 64'd1, 1, "Q", 1, 1000, 1, 1});
		directed_rows.push_back('{1, "\377", 64'd1, 0, "\377", 1, 1000, 1, 1});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.reconfig) begin
				packed_query = pack_query(row.query);
				load_query(packed_query[CFG_DATA_W-1:0], packed_query[2*CFG_DATA_W-1:CFG_DATA_W],
					row.len_word, row.stray);
			end
			text_buf.delete();
			for (int i = 0; i < row.text.len(); i++) begin
				text_buf.push_back(row.text[i]);
			end
			typed.match_score   = SCORE_W'(row.score);
			typed.matched       = row.hit;
			typed.was_substring = row.exact;
			send_text(row.pinned, typed);
		end

		// Random traffic under three idling mixes
		run_phase(34, 64, RANDOM_ITEMS / 3);
		run_phase(64, 34, RANDOM_ITEMS / 3);
		run_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		// Long text: place the first hit late enough that the substring score goes negative
		packed_query = pack_query("end");
		load_query(packed_query[CFG_DATA_W-1:0], packed_query[2*CFG_DATA_W-1:CFG_DATA_W],
			64'd3, 1'b0);
		text_buf.delete();
		repeat (LONG_TEXT_CHARS) text_buf.push_back(CHAR_W'($urandom_range(8'h30, 8'h39)));
		text_buf.push_back(8'h65);
		text_buf.push_back(8'h4E);
		text_buf.push_back(8'h64);
		send_text(1'b0, '0);

		wait_drained();
		if (pending_scores.size() != 0) begin
			flag_error($sformatf("%0d expected scores never arrived", pending_scores.size()));
		end

		$display("Run covered %0d texts (%0d characters) and %0d register writes.",
			texts_sent, chars_sent, cfg_writes);
		$display("Scores checked: %0d substring, %0d subsequence, %0d unmatched; %0d errors.",
			exact_count, fuzzy_count, miss_count, error_count);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/fms_pkg.sv
hw/rtl/fms_if.sv
hw/rtl/fms_in_stage.sv
hw/rtl/fms_score_core.sv
hw/rtl/fuzzy_match_scorer_core.sv
hw/rtl/fms_checker.sv
verif/tb_top.sv
